/* rtl/h2s_pkg.sv */
// Package for the HTTP/2 stream state and flow-control block.
// Holds command codes, lifecycle states and fixed field widths; no dependencies.
package h2s_pkg;

  // Fixed field widths
  localparam int CMD_W    = 4;
  localparam int STATE_W  = 3;
  localparam int AMOUNT_W = 32;
  localparam int OUTWIN_W = 32;
  localparam int INITW_W  = 31;

  // Window math width: a 32-bit window plus the difference of a 32-bit amount and a window needs two guard bits
  localparam int CALC_W = AMOUNT_W + 2;

  // Initial window value after reset
  localparam logic [INITW_W-1:0] INIT_WIN_RST = INITW_W'(65535);

  typedef enum logic [CMD_W-1:0] {
    CMD_HDR_SENT    = 4'd0,
    CMD_HDR_RECV    = 4'd1,
    CMD_DATA_SENT   = 4'd2,
    CMD_DATA_RECV   = 4'd3,
    CMD_RST         = 4'd4,
    CMD_PUSH_SENT   = 4'd5,
    CMD_PUSH_RECV   = 4'd6,
    CMD_UPD_SEND    = 4'd7,
    CMD_UPD_RECV    = 4'd8,
    CMD_USE_SEND    = 4'd9,
    CMD_USE_RECV    = 4'd10,
    CMD_NEW_INITIAL = 4'd11,
    CMD_INIT        = 4'd12
  } cmd_t;

  typedef enum logic [STATE_W-1:0] {
    ST_IDLE       = 3'd0,
    ST_RES_LOCAL  = 3'd1,
    ST_RES_REMOTE = 3'd2,
    ST_OPEN       = 3'd3,
    ST_HC_LOCAL   = 3'd4,
    ST_HC_REMOTE  = 3'd5,
    ST_CLOSED     = 3'd6
  } state_t;

endpackage

/* rtl/h2s_ifs.sv */
// Valid/ready channel interfaces for stream events and stream results.
// Depends on h2s_pkg for field widths.
interface h2s_in_if;
  logic                              valid;
  logic                              ready;
  logic [h2s_pkg::CMD_W-1:0]         command;
  logic                              eos;
  logic signed [h2s_pkg::AMOUNT_W-1:0] amount;

  modport source (output valid, command, eos, amount, input ready);
  modport sink   (input valid, command, eos, amount, output ready);
endinterface

interface h2s_out_if;
  logic                                valid;
  logic                                ready;
  logic [h2s_pkg::STATE_W-1:0]         stream_state;
  logic signed [h2s_pkg::OUTWIN_W-1:0] send_window_out;
  logic signed [h2s_pkg::OUTWIN_W-1:0] recv_window_out;
  logic                                error;

  modport source (output valid, stream_state, send_window_out, recv_window_out, error,
                  input ready);
  modport sink   (input valid, stream_state, send_window_out, recv_window_out, error,
                  output ready);
endinterface

/* rtl/http2_stream_state_flow_control.sv */
// HTTP/2 stream lifecycle and flow-control windows, one result per event beat.
// The result beat follows its input beat in the next cycle. Throughput: one beat per cycle;
// the state update and the result register are written in the same single pass.
// A waiting result stalls input only when the result register is full and not taken.
// Reset (synchronous, rst_n low): state idle, windows and base at min(65535, window max),
// initial_window at 65535, no result pending.
module http2_stream_state_flow_control #(
  parameter int WINDOW_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  h2s_in_if.sink                       in_ch,
  h2s_out_if.source                    out_ch,
  input  logic                         cfg_wr_en,
  input  logic [h2s_pkg::INITW_W-1:0]  cfg_wr_data
);

  localparam longint WMAX_L = (longint'(1) << (WINDOW_BITS - 1)) - 1;
  localparam longint RST_L  = (WMAX_L < 65535) ? WMAX_L : 65535;
  localparam logic signed [WINDOW_BITS-1:0] WIN_RST = WINDOW_BITS'(RST_L);

  h2s_pkg::state_t                      state_r, state_nxt;
  logic signed [WINDOW_BITS-1:0]        send_win_r, recv_win_r, base_win_r;
  logic signed [WINDOW_BITS-1:0]        send_nxt, recv_nxt, base_nxt;
  logic [h2s_pkg::INITW_W-1:0]          init_win_r;
  logic                                 flow_err;
  logic                                 out_valid_r;
  h2s_pkg::state_t                      res_state_r;
  logic signed [WINDOW_BITS-1:0]        res_send_r, res_recv_r;
  logic                                 res_err_r;
  h2s_pkg::cmd_t                        cmd;
  logic                                 accept;

  assign cmd          = h2s_pkg::cmd_t'(in_ch.command);
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;

  // Window arithmetic
  h2s_flow_unit #(.WINDOW_BITS(WINDOW_BITS)) u_flow (
    .cmd      (cmd),
    .amount   (in_ch.amount),
    .send_win (send_win_r),
    .recv_win (recv_win_r),
    .base_win (base_win_r),
    .init_win (init_win_r),
    .send_nxt (send_nxt),
    .recv_nxt (recv_nxt),
    .base_nxt (base_nxt),
    .err      (flow_err)
  );

  // Lifecycle next state
  always_comb begin
    state_nxt = state_r;
    case (cmd)
      h2s_pkg::CMD_HDR_SENT: begin
        if (state_r == h2s_pkg::ST_IDLE || state_r == h2s_pkg::ST_RES_LOCAL)
          state_nxt = in_ch.eos ? h2s_pkg::ST_HC_LOCAL : h2s_pkg::ST_OPEN;
        else if (state_r == h2s_pkg::ST_OPEN && in_ch.eos)
          state_nxt = h2s_pkg::ST_HC_LOCAL;
        else if (state_r == h2s_pkg::ST_HC_REMOTE && in_ch.eos)
          state_nxt = h2s_pkg::ST_CLOSED;
      end
      h2s_pkg::CMD_HDR_RECV: begin
        if (state_r == h2s_pkg::ST_IDLE || state_r == h2s_pkg::ST_RES_REMOTE)
          state_nxt = in_ch.eos ? h2s_pkg::ST_HC_REMOTE : h2s_pkg::ST_OPEN;
        else if (state_r == h2s_pkg::ST_OPEN && in_ch.eos)
          state_nxt = h2s_pkg::ST_HC_REMOTE;
        else if (state_r == h2s_pkg::ST_HC_LOCAL && in_ch.eos)
          state_nxt = h2s_pkg::ST_CLOSED;
      end
      h2s_pkg::CMD_DATA_SENT: begin
        if (state_r == h2s_pkg::ST_OPEN && in_ch.eos)
          state_nxt = h2s_pkg::ST_HC_LOCAL;
        else if (state_r == h2s_pkg::ST_HC_REMOTE && in_ch.eos)
          state_nxt = h2s_pkg::ST_CLOSED;
      end
      h2s_pkg::CMD_DATA_RECV: begin
        if (state_r == h2s_pkg::ST_OPEN && in_ch.eos)
          state_nxt = h2s_pkg::ST_HC_REMOTE;
        else if (state_r == h2s_pkg::ST_HC_LOCAL && in_ch.eos)
          state_nxt = h2s_pkg::ST_CLOSED;
      end
      h2s_pkg::CMD_RST: state_nxt = h2s_pkg::ST_CLOSED;
      h2s_pkg::CMD_PUSH_SENT: begin
        if (state_r == h2s_pkg::ST_IDLE) state_nxt = h2s_pkg::ST_RES_LOCAL;
      end
      h2s_pkg::CMD_PUSH_RECV: begin
        if (state_r == h2s_pkg::ST_IDLE) state_nxt = h2s_pkg::ST_RES_REMOTE;
      end
      h2s_pkg::CMD_INIT: state_nxt = h2s_pkg::ST_IDLE;
      default: begin
      end
    endcase
  end

  // Hold the configured initial window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_win_r <= h2s_pkg::INIT_WIN_RST;
    end else if (cfg_wr_en) begin
      init_win_r <= cfg_wr_data;
    end
  end

  // Advance stream state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= h2s_pkg::ST_IDLE;
      send_win_r <= WIN_RST;
      recv_win_r <= WIN_RST;
      base_win_r <= WIN_RST;
    end else if (accept) begin
      state_r    <= state_nxt;
      send_win_r <= send_nxt;
      recv_win_r <= recv_nxt;
      base_win_r <= base_nxt;
    end
  end

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_state_r <= state_nxt;
      res_send_r  <= send_nxt;
      res_recv_r  <= recv_nxt;
      res_err_r   <= flow_err;
    end
  end

  // Drive the result beat, windows sign-extended
  always_comb begin
    out_ch.valid           = out_valid_r;
    out_ch.stream_state    = res_state_r;
    out_ch.send_window_out = h2s_pkg::OUTWIN_W'(res_send_r);
    out_ch.recv_window_out = h2s_pkg::OUTWIN_W'(res_recv_r);
    out_ch.error           = res_err_r;
  end

endmodule

/* rtl/h2s_flow_unit.sv */
// Flow-control window arithmetic: next send, receive and base windows plus error.
// Combinational; depends on h2s_pkg.
module h2s_flow_unit #(
  parameter int WINDOW_BITS = 32
) (
  input  h2s_pkg::cmd_t                       cmd,
  input  logic signed [h2s_pkg::AMOUNT_W-1:0] amount,
  input  logic signed [WINDOW_BITS-1:0]       send_win,
  input  logic signed [WINDOW_BITS-1:0]       recv_win,
  input  logic signed [WINDOW_BITS-1:0]       base_win,
  input  logic [h2s_pkg::INITW_W-1:0]         init_win,
  output logic signed [WINDOW_BITS-1:0]       send_nxt,
  output logic signed [WINDOW_BITS-1:0]       recv_nxt,
  output logic signed [WINDOW_BITS-1:0]       base_nxt,
  output logic                                err
);

  localparam int CW = h2s_pkg::CALC_W;
  localparam longint WMAX_L = (longint'(1) << (WINDOW_BITS - 1)) - 1;
  localparam logic signed [CW-1:0] WMAX_X = CW'(WMAX_L);
  localparam logic signed [CW-1:0] WMIN_X = CW'(-WMAX_L - 1);

  logic signed [CW-1:0] amt_x, sw_x, rw_x, bw_x, init_x, init_sat;
  logic signed [CW-1:0] send_add, recv_add, send_sub, recv_sub, diff, set_sum;
  logic                 amt_neg, amt_nonpos, diff_neg, diff_pos;

  // Widen all operands so no sum can wrap
  assign amt_x  = CW'(amount);
  assign sw_x   = CW'(send_win);
  assign rw_x   = CW'(recv_win);
  assign bw_x   = CW'(base_win);
  assign init_x = signed'(CW'(init_win));

  assign send_add = sw_x + amt_x;
  assign recv_add = rw_x + amt_x;
  assign send_sub = sw_x - amt_x;
  assign recv_sub = rw_x - amt_x;
  assign diff     = amt_x - bw_x;
  assign set_sum  = sw_x + diff;
  assign init_sat = (init_x > WMAX_X) ? WMAX_X : init_x;

  assign amt_neg    = amt_x[CW-1];
  assign amt_nonpos = amt_neg || (amt_x == '0);
  assign diff_neg   = diff[CW-1];
  assign diff_pos   = !diff_neg && (diff != '0);

  // Select the window update for this command
  always_comb begin
    send_nxt = send_win;
    recv_nxt = recv_win;
    base_nxt = base_win;
    err      = 1'b0;
    case (cmd)
      h2s_pkg::CMD_UPD_SEND: begin
        if (amt_nonpos || (send_add > WMAX_X)) err = 1'b1;
        else send_nxt = send_add[WINDOW_BITS-1:0];
      end
      h2s_pkg::CMD_UPD_RECV: begin
        if (amt_nonpos || (recv_add > WMAX_X)) err = 1'b1;
        else recv_nxt = recv_add[WINDOW_BITS-1:0];
      end
      h2s_pkg::CMD_USE_SEND: begin
        if (amt_neg || (amt_x > sw_x)) err = 1'b1;
        else send_nxt = send_sub[WINDOW_BITS-1:0];
      end
      h2s_pkg::CMD_USE_RECV: begin
        if (amt_neg || (amt_x > rw_x)) err = 1'b1;
        else recv_nxt = recv_sub[WINDOW_BITS-1:0];
      end
      h2s_pkg::CMD_NEW_INITIAL: begin
        if (amt_neg || (amt_x > WMAX_X)) begin
          err = 1'b1;
        end else begin
          // Shift the send window by the change in initial size
          if (diff_pos) begin
            if (set_sum > WMAX_X) err = 1'b1;
            else send_nxt = set_sum[WINDOW_BITS-1:0];
          end else if (diff_neg) begin
            if (set_sum < WMIN_X) begin
              send_nxt = WMIN_X[WINDOW_BITS-1:0];
              err      = 1'b1;
            end else begin
              send_nxt = set_sum[WINDOW_BITS-1:0];
            end
          end
          base_nxt = amt_x[WINDOW_BITS-1:0];
        end
      end
      h2s_pkg::CMD_INIT: begin
        send_nxt = init_sat[WINDOW_BITS-1:0];
        recv_nxt = init_sat[WINDOW_BITS-1:0];
        base_nxt = init_sat[WINDOW_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule
